/* src/stk_pkg.sv */
// Shared types and codes for the stack engine with reverse and min/max query.
`timescale 1ns / 1ps
`default_nettype none
package stk_pkg;

  localparam int DEPTH_DEF = 128;
  localparam int WORD_W    = 32;
  localparam int OCC_W     = 8;

  localparam logic [WORD_W-1:0] WORD_MIN = 32'h8000_0000;
  localparam logic [WORD_W-1:0] WORD_MAX = 32'h7FFF_FFFF;

  localparam logic [2:0] ACT_PUSH    = 3'd0;
  localparam logic [2:0] ACT_POP     = 3'd1;
  localparam logic [2:0] ACT_PEEK    = 3'd2;
  localparam logic [2:0] ACT_REVERSE = 3'd3;
  localparam logic [2:0] ACT_MAX     = 3'd4;
  localparam logic [2:0] ACT_MIN     = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;

  localparam logic [1:0] WR_NONE = 2'd0;
  localparam logic [1:0] WR_PUSH = 2'd1;
  localparam logic [1:0] WR_LO   = 2'd2;
  localparam logic [1:0] WR_HI   = 2'd3;

  localparam logic [2:0] RD_ZERO = 3'd0;
  localparam logic [2:0] RD_TOP  = 3'd1;
  localparam logic [2:0] RD_LO   = 3'd2;
  localparam logic [2:0] RD_HI   = 3'd3;
  localparam logic [2:0] RD_IDX  = 3'd4;

  localparam logic [2:0] DS_ZERO = 3'd0;
  localparam logic [2:0] DS_MIN  = 3'd1;
  localparam logic [2:0] DS_MAX  = 3'd2;
  localparam logic [2:0] DS_RD   = 3'd3;
  localparam logic [2:0] DS_ACC  = 3'd4;

  typedef struct packed {
    logic [1:0] wr_sel;
    logic [2:0] rd_sel;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       rev_init;
    logic       rev_step;
    logic       tmp_load;
    logic       scan_init;
    logic       scan_step;
    logic       scan_max;
    logic       emit;
    logic [1:0] status;
    logic [2:0] data_sel;
  } stk_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic lo_lt_hi;
    logic scan_last;
  } stk_stat_t;

endpackage
`default_nettype wire

/* src/stk_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module stk_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

/* src/stk_ctrl.sv */
// Controller state machine that sequences every stack action.
`timescale 1ns / 1ps
`default_nettype none
module stk_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic [2:0]          action,
  input  wire stk_pkg::stk_stat_t  stat,
  output stk_pkg::stk_cmd_t        cmd,
  output logic                     busy
);

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_TOP       = 3'd1;
  localparam logic [2:0] S_REV_CHK   = 3'd2;
  localparam logic [2:0] S_REV_RD_HI = 3'd3;
  localparam logic [2:0] S_REV_WR_LO = 3'd4;
  localparam logic [2:0] S_REV_WR_HI = 3'd5;
  localparam logic [2:0] S_SCAN      = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic [2:0] act_r;
  logic [2:0] act_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      act_r   <= stk_pkg::ACT_PUSH;
    end else begin
      state_r <= state_nxt;
      act_r   <= act_nxt;
    end
  end

  always_comb begin
    cmd          = '0;
    cmd.wr_sel   = stk_pkg::WR_NONE;
    cmd.rd_sel   = stk_pkg::RD_ZERO;
    cmd.status   = stk_pkg::ST_OK;
    cmd.data_sel = stk_pkg::DS_ZERO;
    state_nxt    = state_r;
    act_nxt      = act_r;
    cmd.scan_max = (act_r == stk_pkg::ACT_MAX);
    case (state_r)
      S_IDLE: begin
        cmd.scan_max = (action == stk_pkg::ACT_MAX);
        if (start) begin
          act_nxt = action;
          case (action)
            stk_pkg::ACT_PUSH: begin
              cmd.emit = 1'b1;
              if (stat.full) begin
                cmd.status = stk_pkg::ST_OVERFLOW;
              end else begin
                cmd.wr_sel  = stk_pkg::WR_PUSH;
                cmd.cnt_inc = 1'b1;
              end
            end
            stk_pkg::ACT_POP, stk_pkg::ACT_PEEK: begin
              if (stat.empty) begin
                cmd.emit     = 1'b1;
                cmd.status   = stk_pkg::ST_EMPTY;
                cmd.data_sel = stk_pkg::DS_MIN;
              end else begin
                cmd.rd_sel = stk_pkg::RD_TOP;
                state_nxt  = S_TOP;
              end
            end
            stk_pkg::ACT_REVERSE: begin
              if (stat.empty) begin
                cmd.emit   = 1'b1;
                cmd.status = stk_pkg::ST_EMPTY;
              end else begin
                cmd.rev_init = 1'b1;
                state_nxt    = S_REV_CHK;
              end
            end
            stk_pkg::ACT_MAX, stk_pkg::ACT_MIN: begin
              if (stat.empty) begin
                cmd.emit     = 1'b1;
                cmd.status   = stk_pkg::ST_EMPTY;
                cmd.data_sel = (action == stk_pkg::ACT_MAX) ? stk_pkg::DS_MIN
                                                             : stk_pkg::DS_MAX;
              end else begin
                cmd.scan_init = 1'b1;
                cmd.rd_sel    = stk_pkg::RD_ZERO;
                state_nxt     = S_SCAN;
              end
            end
            default: begin
              cmd.emit = 1'b1;
            end
          endcase
        end
      end
      S_TOP: begin
        cmd.emit     = 1'b1;
        cmd.data_sel = stk_pkg::DS_RD;
        cmd.cnt_dec  = (act_r == stk_pkg::ACT_POP);
        state_nxt    = S_IDLE;
      end
      S_REV_CHK: begin
        if (stat.lo_lt_hi) begin
          cmd.rd_sel = stk_pkg::RD_LO;
          state_nxt  = S_REV_RD_HI;
        end else begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_REV_RD_HI: begin
        cmd.tmp_load = 1'b1;
        cmd.rd_sel   = stk_pkg::RD_HI;
        state_nxt    = S_REV_WR_LO;
      end
      S_REV_WR_LO: begin
        cmd.wr_sel = stk_pkg::WR_LO;
        state_nxt  = S_REV_WR_HI;
      end
      S_REV_WR_HI: begin
        cmd.wr_sel   = stk_pkg::WR_HI;
        cmd.rev_step = 1'b1;
        state_nxt    = S_REV_CHK;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) begin
          cmd.emit     = 1'b1;
          cmd.data_sel = stk_pkg::DS_ACC;
          state_nxt    = S_IDLE;
        end else begin
          cmd.rd_sel = stk_pkg::RD_IDX;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule
`default_nettype wire

/* src/stk_dp.sv */
// Datapath: entry memory, count, reversal pointers, scan accumulator and result registers.
`timescale 1ns / 1ps
`default_nettype none
module stk_dp #(
  parameter int DEPTH = stk_pkg::DEPTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic signed [stk_pkg::WORD_W-1:0] in_value,
  input  wire stk_pkg::stk_cmd_t                cmd,
  output stk_pkg::stk_stat_t                    stat,
  output logic                                  out_valid,
  output logic signed [stk_pkg::WORD_W-1:0]     out_data,
  output logic        [1:0]                     out_status,
  output logic        [stk_pkg::OCC_W-1:0]      out_occupancy
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic [CW-1:0] count_m1;
  logic [CW-1:0] idx_r;
  logic [AW-1:0] lo_r;
  logic [AW-1:0] hi_r;
  logic signed [stk_pkg::WORD_W-1:0] acc_r;
  logic signed [stk_pkg::WORD_W-1:0] acc_upd;
  logic [stk_pkg::WORD_W-1:0] tmp_r;
  logic [stk_pkg::WORD_W-1:0] rd_data;
  logic [stk_pkg::WORD_W-1:0] wdata;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  logic          we;
  logic [stk_pkg::WORD_W-1:0] res_data;
  logic          out_valid_r;
  logic [stk_pkg::WORD_W-1:0] out_data_r;
  logic [1:0]    out_status_r;
  logic [stk_pkg::OCC_W-1:0] out_occ_r;

  assign count_m1 = count_r - CW'(1);

  always_comb begin
    count_nxt = count_r;
    if (cmd.cnt_inc) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.cnt_dec) begin
      count_nxt = count_m1;
    end
  end

  always_comb begin
    we    = 1'b1;
    waddr = count_r[AW-1:0];
    wdata = in_value;
    case (cmd.wr_sel)
      stk_pkg::WR_PUSH: begin
        waddr = count_r[AW-1:0];
        wdata = in_value;
      end
      stk_pkg::WR_LO: begin
        waddr = lo_r;
        wdata = rd_data;
      end
      stk_pkg::WR_HI: begin
        waddr = hi_r;
        wdata = tmp_r;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_comb begin
    case (cmd.rd_sel)
      stk_pkg::RD_TOP: raddr = count_m1[AW-1:0];
      stk_pkg::RD_LO:  raddr = lo_r;
      stk_pkg::RD_HI:  raddr = hi_r;
      stk_pkg::RD_IDX: raddr = idx_r[AW-1:0];
      default:         raddr = '0;
    endcase
  end

  stk_ram #(
    .WIDTH (stk_pkg::WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rd_data)
  );

  always_comb begin
    acc_upd = acc_r;
    if (cmd.scan_max) begin
      if ($signed(rd_data) > acc_r) begin
        acc_upd = $signed(rd_data);
      end
    end else begin
      if ($signed(rd_data) < acc_r) begin
        acc_upd = $signed(rd_data);
      end
    end
  end

  always_comb begin
    case (cmd.data_sel)
      stk_pkg::DS_MIN: res_data = stk_pkg::WORD_MIN;
      stk_pkg::DS_MAX: res_data = stk_pkg::WORD_MAX;
      stk_pkg::DS_RD:  res_data = rd_data;
      stk_pkg::DS_ACC: res_data = acc_upd;
      default:         res_data = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rev_init) begin
      lo_r <= '0;
      hi_r <= count_m1[AW-1:0];
    end else if (cmd.rev_step) begin
      lo_r <= lo_r + AW'(1);
      hi_r <= hi_r - AW'(1);
    end
    if (cmd.tmp_load) begin
      tmp_r <= rd_data;
    end
    if (cmd.scan_init) begin
      acc_r <= cmd.scan_max ? stk_pkg::WORD_MIN : stk_pkg::WORD_MAX;
      idx_r <= CW'(1);
    end else if (cmd.scan_step) begin
      acc_r <= acc_upd;
      idx_r <= idx_r + CW'(1);
    end
    if (cmd.emit) begin
      out_data_r   <= res_data;
      out_status_r <= cmd.status;
      out_occ_r    <= stk_pkg::OCC_W'(count_nxt);
    end
  end

  assign stat.empty     = (count_r == '0);
  assign stat.full      = (count_r == CW'(DEPTH));
  assign stat.lo_lt_hi  = (lo_r < hi_r);
  assign stat.scan_last = (idx_r == count_r);

  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;
  assign out_status    = out_status_r;
  assign out_occupancy = out_occ_r;

endmodule
`default_nettype wire

/* src/stack_engine_with_reverse_min_max_core.sv */
// Top level of the LIFO stack engine with reversal and min/max query.
// Push, overflow, every empty case: result next cycle; the next item may follow at once.
// Pop and peek: top entry read through the registered memory port, then the result register.
// Reverse: check, read hi, write lo, write hi per swap; min and max read every entry held.
// All timing is set by the single read and single write port of the entry memory.
// Reset empties the stack at once; entry memory contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module stack_engine_with_reverse_min_max_core #(
  parameter int DEPTH = stk_pkg::DEPTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic        [2:0]                 in_action,
  input  wire logic signed [stk_pkg::WORD_W-1:0] in_value,
  output logic                                   out_valid,
  output logic signed [stk_pkg::WORD_W-1:0]      out_data,
  output logic        [1:0]                      out_status,
  output logic        [stk_pkg::OCC_W-1:0]       out_occupancy
);

  stk_pkg::stk_cmd_t  cmd;
  stk_pkg::stk_stat_t stat;

  stk_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .action (in_action),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy)
  );

  stk_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_value      (in_value),
    .cmd           (cmd),
    .stat          (stat),
    .out_valid     (out_valid),
    .out_data      (out_data),
    .out_status    (out_status),
    .out_occupancy (out_occupancy)
  );

endmodule
`default_nettype wire

/* bench/stack_result_checker.sv */
// Checker for the stack engine: predicts every result and compares it with the block's output.
`timescale 1ns / 1ps
module stack_result_checker #(
  parameter int DEPTH = stk_pkg::DEPTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  input  wire logic                              busy,
  input  wire logic        [2:0]                 in_action,
  input  wire logic signed [stk_pkg::WORD_W-1:0] in_value,
  input  wire logic                              out_valid,
  input  wire logic signed [stk_pkg::WORD_W-1:0] out_data,
  input  wire logic        [1:0]                 out_status,
  input  wire logic        [stk_pkg::OCC_W-1:0]  out_occupancy,
  output int                                     errors,
  output int                                     outstanding
);
  import stk_pkg::*;

  typedef struct packed {
    logic signed [WORD_W-1:0] data;
    logic [1:0]               status;
    logic [OCC_W-1:0]         occupancy;
  } stack_result_t;

  logic signed [WORD_W-1:0] shadow_words [DEPTH];
  int                       shadow_count = 0;
  stack_result_t            pending_results [$];

  initial begin
    errors = 0;
    outstanding = 0;
  end

  function automatic stack_result_t apply_action(logic [2:0] act,
                                                 logic signed [WORD_W-1:0] val);
    stack_result_t            r;
    logic signed [WORD_W-1:0] swap_word;
    int                       lo;
    int                       hi;
    r.data = '0;
    r.status = ST_OK;
    case (act)
      ACT_PUSH: begin
        if (shadow_count >= DEPTH) begin
          r.status = ST_OVERFLOW;
        end else begin
          shadow_words[shadow_count] = val;
          shadow_count++;
        end
      end
      ACT_POP, ACT_PEEK: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
          r.data = WORD_MIN;
        end else begin
          r.data = shadow_words[shadow_count-1];
          if (act == ACT_POP) shadow_count--;
        end
      end
      ACT_REVERSE: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          lo = 0;
          hi = shadow_count - 1;
          while (lo < hi) begin
            swap_word = shadow_words[lo];
            shadow_words[lo] = shadow_words[hi];
            shadow_words[hi] = swap_word;
            lo++;
            hi--;
          end
        end
      end
      ACT_MAX: begin
        r.data = WORD_MIN;
        if (shadow_count == 0) r.status = ST_EMPTY;
        for (lo = 0; lo < shadow_count; lo++) begin
          if (shadow_words[lo] > r.data) r.data = shadow_words[lo];
        end
      end
      ACT_MIN: begin
        r.data = WORD_MAX;
        if (shadow_count == 0) r.status = ST_EMPTY;
        for (lo = 0; lo < shadow_count; lo++) begin
          if (shadow_words[lo] < r.data) r.data = shadow_words[lo];
        end
      end
      default: begin
      end
    endcase
    r.occupancy = shadow_count[OCC_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    stack_result_t want;
    if (rst_n) begin
      if (out_valid) begin
        if (pending_results.size() == 0) begin
          if (errors < 10) begin
            $display("unexpected result: data %h status %0d occupancy %0d",
                     out_data, out_status, out_occupancy);
          end
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (out_data !== want.data || out_status !== want.status ||
              out_occupancy !== want.occupancy) begin
            if (errors < 10) begin
              $display("result mismatch: expected %h/%0d/%0d, got %h/%0d/%0d",
                       want.data, want.status, want.occupancy,
                       out_data, out_status, out_occupancy);
            end
            errors++;
          end
        end
      end
      if (start && !busy) begin
        pending_results.push_back(apply_action(in_action, in_value));
      end
      outstanding = pending_results.size();
    end
  end

endmodule

/* bench/stack_engine_with_reverse_min_max_core_test.sv */
// Testbench top for the stack engine: clock, reset, directed and random stimulus, verdict.
`timescale 1ns / 1ps
module stack_engine_with_reverse_min_max_core_test;
  import stk_pkg::*;

  localparam logic [2:0] ACT_SPARE6 = 3'd6;
  localparam logic [2:0] ACT_SPARE7 = 3'd7;

  localparam int MODE_FILL  = 0;
  localparam int MODE_MIX   = 1;
  localparam int MODE_DRAIN = 2;

  localparam int RANDOM_ITEMS = 1500;
  localparam int PHASE_LEN    = 200;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic [2:0]               in_action = ACT_PUSH;
  logic signed [WORD_W-1:0] in_value = '0;
  logic                     out_valid;
  logic signed [WORD_W-1:0] out_data;
  logic [1:0]               out_status;
  logic [OCC_W-1:0]         out_occupancy;
  int                       errors;
  int                       outstanding;
  bit                       gaps_on = 1'b1;

  stack_engine_with_reverse_min_max_core uut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_action(in_action),
    .in_value(in_value),
    .out_valid(out_valid),
    .out_data(out_data),
    .out_status(out_status),
    .out_occupancy(out_occupancy)
  );

  stack_result_checker checker_i (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_action(in_action),
    .in_value(in_value),
    .out_valid(out_valid),
    .out_data(out_data),
    .out_status(out_status),
    .out_occupancy(out_occupancy),
    .errors(errors),
    .outstanding(outstanding)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic send_item(logic [2:0] act, logic signed [WORD_W-1:0] val);
    while (gaps_on && $urandom_range(99) < 12) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_action <= act;
    in_value <= val;
    do @(posedge clk); while (busy);
  endtask

  function automatic logic [2:0] pick_action(int mode);
    int r;
    r = $urandom_range(99);
    case (mode)
      MODE_FILL: begin
        if (r < 88) return ACT_PUSH;
        if (r < 93) return ACT_POP;
        if (r < 95) return ACT_PEEK;
        if (r < 97) return ACT_MAX;
        if (r < 99) return ACT_MIN;
        return ACT_REVERSE;
      end
      MODE_DRAIN: begin
        if (r < 12) return ACT_PUSH;
        if (r < 72) return ACT_POP;
        if (r < 80) return ACT_PEEK;
        if (r < 86) return ACT_REVERSE;
        if (r < 92) return ACT_MAX;
        if (r < 98) return ACT_MIN;
        return ACT_SPARE7;
      end
      default: begin
        if (r < 34) return ACT_PUSH;
        if (r < 54) return ACT_POP;
        if (r < 64) return ACT_PEEK;
        if (r < 74) return ACT_REVERSE;
        if (r < 84) return ACT_MAX;
        if (r < 94) return ACT_MIN;
        if (r < 97) return ACT_SPARE6;
        return ACT_SPARE7;
      end
    endcase
  endfunction

  function automatic logic signed [WORD_W-1:0] pick_value();
    int small_val;
    small_val = int'($urandom_range(16)) - 8;
    case ($urandom_range(9))
      0: return WORD_MIN;
      1: return WORD_MAX;
      2, 3: return small_val;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int mode;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(ACT_POP, 32'sd5);
    send_item(ACT_PEEK, '0);
    send_item(ACT_REVERSE, '0);
    send_item(ACT_MAX, '0);
    send_item(ACT_MIN, '0);
    send_item(ACT_SPARE6, 32'sd9);
    send_item(ACT_SPARE7, -32'sd1);
    send_item(ACT_PUSH, 32'sh1234_5678);
    send_item(ACT_REVERSE, '0);
    send_item(ACT_POP, '0);
    send_item(ACT_PUSH, WORD_MIN);
    send_item(ACT_PUSH, WORD_MAX);
    send_item(ACT_PUSH, '0);
    send_item(ACT_PUSH, -32'sd1);
    send_item(ACT_PUSH, 32'sh5555_5555);
    send_item(ACT_PUSH, 32'shAAAA_AAAA);
    send_item(ACT_PEEK, '0);
    send_item(ACT_MAX, '0);
    send_item(ACT_MIN, '0);
    send_item(ACT_REVERSE, '0);
    send_item(ACT_PEEK, '0);
    send_item(ACT_SPARE6, '0);
    send_item(ACT_POP, '0);
    send_item(ACT_POP, '0);
    send_item(ACT_MAX, '0);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      case ((n / PHASE_LEN) % 4)
        0: mode = MODE_FILL;
        2: mode = MODE_DRAIN;
        default: mode = MODE_MIX;
      endcase
      gaps_on = !(n >= 600 && n < 900);
      send_item(pick_action(mode), pick_value());
    end
    start <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
